// ===== rtl/dml_pkg.sv =====
`timescale 1ns / 1ps

package dml_pkg;

    // Widths of the bus fields.
    localparam int DATA_W = 32;
    localparam int ADDR_W = 8;
    localparam int SIZE_W = 4;
    localparam int OP_W   = 2;
    localparam int RSP_W  = 2;

    // Spill queue of launched descriptors.
    localparam int SPILL_DEPTH = 2;
    localparam int SPILL_IDX_W = (SPILL_DEPTH > 1) ? $clog2(SPILL_DEPTH) : 1;
    localparam int SPILL_SUM_W = SPILL_IDX_W + 1;
    localparam int SPILL_CNT_W = $clog2(SPILL_DEPTH + 1);

    // Command queue between the front and back parts.
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_IDX_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    // Stream word widths.
    localparam int S_FIELDS_W = ADDR_W + SIZE_W + DATA_W + 1;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = RSP_W + DATA_W + 1 + 3 * DATA_W + 1;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Register offsets.
    localparam logic [ADDR_W-1:0] OFS_SOURCE      = 8'h00;
    localparam logic [ADDR_W-1:0] OFS_DESTINATION = 8'h04;
    localparam logic [ADDR_W-1:0] OFS_LENGTH      = 8'h08;
    localparam logic [ADDR_W-1:0] OFS_SETTING     = 8'h0c;
    localparam logic [ADDR_W-1:0] OFS_STATUS      = 8'h10;
    localparam logic [ADDR_W-1:0] OFS_LAUNCH      = 8'h14;
    localparam logic [ADDR_W-1:0] OFS_DONE        = 8'h18;
    localparam logic [SIZE_W-1:0] VALID_BYTES     = 4'd4;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_ACK   = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    typedef enum logic [RSP_W-1:0] {
        RSP_OK      = 2'd0,
        RSP_INVALID = 2'd1,
        RSP_DENIED  = 2'd2
    } t_rsp;

    typedef enum logic [2:0] {
        CMD_INVALID,
        CMD_WRITE,
        CMD_READ,
        CMD_ACK,
        CMD_TICK
    } t_cmd_kind;

    typedef enum logic [2:0] {
        REG_SOURCE,
        REG_DESTINATION,
        REG_LENGTH,
        REG_SETTING,
        REG_STATUS,
        REG_LAUNCH,
        REG_NONE
    } t_reg_sel;

    // Classified word handed from the front part to the back part.
    typedef struct packed {
        t_cmd_kind          kind;
        t_reg_sel           sel;
        logic [DATA_W-1:0]  wdata;
        logic               ready;
    } t_cmd;

    // Source sits in the lowest bits.
    typedef struct packed {
        logic [DATA_W-1:0] len;
        logic [DATA_W-1:0] dst;
        logic [DATA_W-1:0] src;
    } t_desc;

    // Response sits in the lowest bits.
    typedef struct packed {
        logic              retry;
        t_desc             desc;
        logic              desc_valid;
        logic [DATA_W-1:0] rdata;
        t_rsp              rsp;
    } t_result;

endpackage

// ===== rtl/dml_front.sv =====
`timescale 1ns / 1ps

module dml_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dml_pkg::OP_W-1:0]      i_op,
    input  logic [dml_pkg::S_TDATA_W-1:0] i_data,
    output logic                          o_cmd_valid,
    output dml_pkg::t_cmd                 o_cmd,
    input  logic                          i_cmd_full
);
    import dml_pkg::*;

    logic              r_valid;
    t_cmd              r_cmd;
    t_cmd              n_cmd;
    logic [ADDR_W-1:0] w_addr;
    logic [SIZE_W-1:0] w_size;
    t_op               w_op;

    assign w_addr = i_data[ADDR_W-1:0];
    assign w_size = i_data[ADDR_W +: SIZE_W];
    assign w_op   = t_op'(i_op);

    // The holding register frees when its word moves into the queue.
    assign o_ready     = !r_valid || !i_cmd_full;
    assign o_cmd_valid = r_valid;
    assign o_cmd       = r_cmd;

    // Classify the incoming word by operation, size and offset.
    always_comb begin
        n_cmd.wdata = i_data[ADDR_W+SIZE_W +: DATA_W];
        n_cmd.ready = i_data[ADDR_W+SIZE_W+DATA_W];
        case (w_addr)
            OFS_SOURCE:      n_cmd.sel = REG_SOURCE;
            OFS_DESTINATION: n_cmd.sel = REG_DESTINATION;
            OFS_LENGTH:      n_cmd.sel = REG_LENGTH;
            OFS_SETTING:     n_cmd.sel = REG_SETTING;
            OFS_STATUS:      n_cmd.sel = REG_STATUS;
            OFS_DONE:        n_cmd.sel = REG_STATUS;
            OFS_LAUNCH:      n_cmd.sel = REG_LAUNCH;
            default:         n_cmd.sel = REG_NONE;
        endcase
        case (w_op)
            OP_WRITE: n_cmd.kind = (w_size == VALID_BYTES) ? CMD_WRITE : CMD_INVALID;
            OP_READ:  n_cmd.kind = (w_size == VALID_BYTES) ? CMD_READ : CMD_INVALID;
            OP_ACK:   n_cmd.kind = CMD_ACK;
            default:  n_cmd.kind = CMD_TICK;
        endcase
    end

    // Valid flag of the holding register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload of the holding register.
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== rtl/dml_cmd_fifo.sv =====
`timescale 1ns / 1ps

module dml_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dml_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output dml_pkg::t_cmd o_cmd,
    input  logic          i_pop
);
    import dml_pkg::*;

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_IDX_W-1:0] r_head;
    logic [CMDQ_IDX_W-1:0] r_tail;
    logic [CMDQ_CNT_W-1:0] r_count;
    logic                  w_push;
    logic                  w_pop;

    assign o_full  = (r_count == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_head];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_tail <= (r_tail == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            end
            if (w_pop) begin
                r_head <= (r_head == CMDQ_IDX_W'(CMDQ_DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_tail] <= i_cmd;
        end
    end

endmodule

// ===== rtl/dml_back.sv =====
`timescale 1ns / 1ps

module dml_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cmd_valid,
    input  dml_pkg::t_cmd                 i_cmd,
    output logic                          o_cmd_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dml_pkg::M_TDATA_W-1:0] o_data
);
    import dml_pkg::*;

    // Register file and counters.
    logic [DATA_W-1:0]      r_src, n_src;
    logic [DATA_W-1:0]      r_dst, n_dst;
    logic [DATA_W-1:0]      r_len, n_len;
    logic [DATA_W-1:0]      r_set, n_set;
    logic [DATA_W-1:0]      r_issued, n_issued;
    logic [DATA_W-1:0]      r_completed, n_completed;
    logic                   r_retry, n_retry;

    // Spill queue.
    t_desc                  r_spill [SPILL_DEPTH];
    logic [SPILL_IDX_W-1:0] r_head, n_head;
    logic [SPILL_CNT_W-1:0] r_fill, n_fill;
    logic                   w_spill_wr;
    logic [SPILL_IDX_W-1:0] w_tail;
    logic [SPILL_SUM_W-1:0] w_tail_sum;
    t_desc                  w_new_desc;

    // Output register.
    logic                   r_out_valid;
    t_result                r_out, n_out;
    logic                   w_exec;
    logic                   w_spill_full;

    assign w_exec       = i_cmd_valid && (!r_out_valid || i_ready);
    assign o_cmd_pop    = w_exec;
    assign o_valid      = r_out_valid;
    assign o_data       = {{(M_TDATA_W - M_FIELDS_W){1'b0}}, r_out};
    assign w_spill_full = (r_fill == SPILL_CNT_W'(SPILL_DEPTH));

    // Tail slot is head plus fill, wrapped once.
    always_comb begin
        w_tail_sum = SPILL_SUM_W'(r_head) + SPILL_SUM_W'(r_fill);
        if (w_tail_sum >= SPILL_SUM_W'(SPILL_DEPTH)) begin
            w_tail = SPILL_IDX_W'(w_tail_sum - SPILL_SUM_W'(SPILL_DEPTH));
        end else begin
            w_tail = SPILL_IDX_W'(w_tail_sum);
        end
    end

    assign w_new_desc.src = r_src;
    assign w_new_desc.dst = r_dst;
    assign w_new_desc.len = r_len;

    // Carry out one command against the register state.
    always_comb begin
        n_src       = r_src;
        n_dst       = r_dst;
        n_len       = r_len;
        n_set       = r_set;
        n_issued    = r_issued;
        n_completed = r_completed;
        n_retry     = r_retry;
        n_head      = r_head;
        n_fill      = r_fill;
        w_spill_wr  = 1'b0;
        n_out       = '0;
        n_out.rsp   = RSP_OK;
        case (i_cmd.kind)
            CMD_INVALID: begin
                n_out.rsp = RSP_INVALID;
            end
            CMD_WRITE: begin
                case (i_cmd.sel)
                    REG_SOURCE:      n_src = i_cmd.wdata;
                    REG_DESTINATION: n_dst = i_cmd.wdata;
                    REG_LENGTH:      n_len = i_cmd.wdata;
                    REG_SETTING:     n_set = i_cmd.wdata;
                    default:         n_src = r_src;
                endcase
            end
            CMD_READ: begin
                case (i_cmd.sel)
                    REG_SOURCE:      n_out.rdata = r_src;
                    REG_DESTINATION: n_out.rdata = r_dst;
                    REG_LENGTH:      n_out.rdata = r_len;
                    REG_SETTING:     n_out.rdata = r_set;
                    REG_STATUS: begin
                        n_out.rdata = DATA_W'(r_issued == r_completed);
                    end
                    REG_LAUNCH: begin
                        if ((r_len != '0) && w_spill_full) begin
                            // Queue full: deny and owe a retry.
                            n_retry   = 1'b1;
                            n_out.rsp = RSP_DENIED;
                        end else begin
                            n_issued    = r_issued + 1'b1;
                            n_out.rdata = r_issued + 1'b1;
                            if (r_len == '0) begin
                                n_completed = r_completed + 1'b1;
                            end else begin
                                w_spill_wr = 1'b1;
                                n_fill     = r_fill + 1'b1;
                            end
                        end
                    end
                    default: n_out.rdata = '0;
                endcase
            end
            CMD_ACK: begin
                n_completed = r_completed + 1'b1;
            end
            default: begin
                // Tick: hand the oldest descriptor to a ready splitter.
                if ((r_fill != '0) && i_cmd.ready) begin
                    n_out.desc_valid = 1'b1;
                    n_out.desc       = r_spill[r_head];
                    n_fill           = r_fill - 1'b1;
                    n_head = (r_head == SPILL_IDX_W'(SPILL_DEPTH - 1)) ? '0
                                                                       : r_head + 1'b1;
                    if (r_retry) begin
                        n_retry     = 1'b0;
                        n_out.retry = 1'b1;
                    end
                end
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src       <= '0;
            r_dst       <= '0;
            r_len       <= '0;
            r_set       <= '0;
            r_issued    <= '0;
            r_completed <= '0;
            r_retry     <= 1'b0;
            r_head      <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_exec) begin
                r_src       <= n_src;
                r_dst       <= n_dst;
                r_len       <= n_len;
                r_set       <= n_set;
                r_issued    <= n_issued;
                r_completed <= n_completed;
                r_retry     <= n_retry;
                r_head      <= n_head;
                r_fill      <= n_fill;
            end
            if (w_exec) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Spill entries and the result word.
    always_ff @(posedge i_clk) begin
        if (w_exec && w_spill_wr) begin
            r_spill[w_tail] <= w_new_desc;
        end
        if (w_exec) begin
            r_out <= n_out;
        end
    end

endmodule

// ===== rtl/dma_mmio_launch_frontend.sv =====
`timescale 1ns / 1ps
// Path: an accepted word passes the front register, the command queue and the output register.
// Throughput: one word per cycle; the front register, a two-entry command queue and the
// output register let both sides stall on their own without losing a cycle.
// Reset: synchronous, active low; clears registers, counters, queue pointers and the
// retry flag at once, with no clearing pass.
module dma_mmio_launch_frontend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // Fields from bit 0: address, access_bytes, write_data, splitter_ready.
    input  logic [dml_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // Fields from bit 0: operation.
    input  logic [dml_pkg::OP_W-1:0]      s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // Fields from bit 0: response, read_data, descriptor_valid, descriptor_source,
    // descriptor_destination, descriptor_length, retry_request.
    output logic [dml_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import dml_pkg::*;

    logic w_front_valid;
    t_cmd w_front_cmd;
    logic w_q_full;
    logic w_q_valid;
    t_cmd w_q_cmd;
    logic w_q_pop;

    // Front part: accept and classify.
    dml_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_data      (s_axis_tdata),
        .o_cmd_valid (w_front_valid),
        .o_cmd       (w_front_cmd),
        .i_cmd_full  (w_q_full)
    );

    // Command queue between the two parts.
    dml_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_valid),
        .i_cmd   (w_front_cmd),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_q_pop)
    );

    // Back part: registers, counters, spill queue and result word.
    dml_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_q_valid),
        .i_cmd       (w_q_cmd),
        .o_cmd_pop   (w_q_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata)
    );

endmodule
